@@ sv/macp_pkg.sv @@
// ----------------------------------------------------------------------------
// macp_pkg
// shared types and constants for the mac address text parser
// ----------------------------------------------------------------------------
package macp_pkg;

  localparam logic [7:0] ChrColon  = 8'h3A;
  localparam logic [7:0] ChrHyphen = 8'h2D;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrUpA    = 8'h41;
  localparam logic [7:0] ChrUpF    = 8'h46;
  localparam logic [7:0] ChrLoA    = 8'h61;
  localparam logic [7:0] ChrLoF    = 8'h66;

  localparam int unsigned MacW    = 48;
  localparam int unsigned PosW    = 5;
  localparam logic [PosW-1:0] BodyLen = PosW'(17);
  localparam int unsigned MulticastBit = 40;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'b001,
    PH_BODY  = 3'b010,
    PH_TRAIL = 3'b100
  } phase_e;

  typedef struct packed {
    logic       is_ws;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_sep;
  } char_class_t;

endpackage

@@ sv/macp_char_class.sv @@
// ----------------------------------------------------------------------------
// macp_char_class
// classifies one text byte: whitespace, hex digit with value, separator
// ----------------------------------------------------------------------------
module macp_char_class
  import macp_pkg::*;
(
  input  logic [7:0]  char_i,
  output char_class_t class_o
);

  always_comb begin
    class_o.is_ws   = (char_i == ChrSpace) || (char_i inside {[ChrTab:ChrCr]});
    class_o.is_sep  = (char_i == ChrColon) || (char_i == ChrHyphen);
    class_o.is_hex  = 1'b1;
    class_o.hex_val = 4'd0;
    case (char_i) inside
      [ChrZero:ChrNine]: begin
        class_o.hex_val = 4'(char_i - ChrZero);
      end
      [ChrUpA:ChrUpF]: begin
        class_o.hex_val = 4'(char_i - ChrUpA + 8'd10);
      end
      [ChrLoA:ChrLoF]: begin
        class_o.hex_val = 4'(char_i - ChrLoA + 8'd10);
      end
      default: begin
        class_o.is_hex = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/mac_address_text_parser.sv @@
// ----------------------------------------------------------------------------
// mac_address_text_parser
// parses a mac address string one character per request and gives one
// pass/fail result with the 48-bit address on the last character
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_stall_o   char_code_i[7:0], is_last_i
//  out      out  out_valid_o/out_stall_i addr_ok_o, mac_value_o[47:0]
//
// one character is taken every cycle while in_stall_o is low; the parser state
// updates from the input register, and the result is registered when a last
// character leaves the input register. a stalled result holds the input stage only when the
// waiting character is itself a last one. reset clears the parser state and
// both valid registers.
// ----------------------------------------------------------------------------
module mac_address_text_parser
  import macp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      char_code_i,
  input  logic            is_last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            addr_ok_o,
  output logic [MacW-1:0] mac_value_o
);

  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             last_q;

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       sep_q, sep_d;
  logic [MacW-1:0]  addr_q, addr_d;
  logic             nonzero_q, nonzero_d;
  logic             failed_q, failed_d;

  logic             out_valid_q, out_valid_d;
  logic             ok_q;
  logic [MacW-1:0]  mac_q;

  char_class_t      cls;
  logic             advance;
  logic             fire;
  logic             take_body;
  logic             sep_slot;
  logic             ok;

  macp_char_class u_class (
    .char_i  (char_q),
    .class_o (cls)
  );

  assign advance    = !(last_q && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign fire       = in_valid_q && advance;

  always_comb begin
    sep_slot = pos_q inside {PosW'(2), PosW'(5), PosW'(8), PosW'(11), PosW'(14)};
  end

  // next parser state for the registered character
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    sep_d     = sep_q;
    addr_d    = addr_q;
    nonzero_d = nonzero_q;
    failed_d  = failed_q;
    take_body = 1'b0;
    if (!failed_q) begin
      case (phase_q)
        PH_LEAD: begin
          if (!cls.is_ws) begin
            phase_d   = PH_BODY;
            take_body = 1'b1;
          end
        end
        PH_BODY: begin
          if (cls.is_ws) begin
            failed_d = 1'b1;
          end else begin
            take_body = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!cls.is_ws) begin
            failed_d = 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end
    if (take_body) begin
      if (sep_slot) begin
        if (pos_q == PosW'(2)) begin
          if (cls.is_sep) begin
            sep_d = char_q;
          end else begin
            failed_d = 1'b1;
          end
        end else if (char_q != sep_q) begin
          failed_d = 1'b1;
        end
      end else if (!cls.is_hex) begin
        failed_d = 1'b1;
      end else begin
        addr_d = {addr_q[MacW-5:0], cls.hex_val};
        if (cls.hex_val != 4'd0) begin
          nonzero_d = 1'b1;
        end
      end
      pos_d = pos_q + PosW'(1);
      if (pos_d >= BodyLen) begin
        phase_d = PH_TRAIL;
      end
    end
  end

  assign ok = !failed_d && (phase_d == PH_TRAIL) && nonzero_d && !addr_d[MulticastBit];

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (fire && last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      last_q      <= 1'b0;
      phase_q     <= PH_LEAD;
      pos_q       <= '0;
      sep_q       <= '0;
      addr_q      <= '0;
      nonzero_q   <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
        last_q     <= is_last_i;
      end
      if (fire) begin
        if (last_q) begin
          phase_q   <= PH_LEAD;
          pos_q     <= '0;
          sep_q     <= '0;
          addr_q    <= '0;
          nonzero_q <= 1'b0;
          failed_q  <= 1'b0;
        end else begin
          phase_q   <= phase_d;
          pos_q     <= pos_d;
          sep_q     <= sep_d;
          addr_q    <= addr_d;
          nonzero_q <= nonzero_d;
          failed_q  <= failed_d;
        end
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q <= char_code_i;
    end
    if (fire && last_q) begin
      ok_q  <= ok;
      mac_q <= ok ? addr_d : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign addr_ok_o   = ok_q;
  assign mac_value_o = mac_q;

endmodule

@@ tb/mac_address_text_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_tb
// self-checking bench for the mac address text parser: address strings,
// mostly well formed with random digits, case and separators, plus corrupted,
// short, padded and noise strings, are fed one character per request while
// both channels stall at random; a model of the parser predicts each
// pass/fail result and address, and a scoreboard checks them in order
// ----------------------------------------------------------------------------
module mac_address_text_parser_tb
  import macp_pkg::*;
();

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic            ok;
    logic [MacW-1:0] mac;
  } addr_res_t;

  class mac_parse_tracker;
    phase_e          phase;
    logic [PosW-1:0] pos;
    logic [7:0]      sep;
    logic [MacW-1:0] shift;
    bit              nonzero;
    bit              dead;
    addr_res_t       pending_addrs[$];
    int              misses;

    function new();
      misses = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase   = PH_LEAD;
      pos     = '0;
      sep     = '0;
      shift   = '0;
      nonzero = 0;
      dead    = 0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == ChrSpace || (c >= ChrTab && c <= ChrCr);
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= ChrZero && c <= ChrNine) return int'(c - ChrZero);
      if (c >= ChrUpA && c <= ChrUpF) return int'(c - ChrUpA) + 10;
      if (c >= ChrLoA && c <= ChrLoF) return int'(c - ChrLoA) + 10;
      return 16;
    endfunction

    function void take_body(logic [7:0] c);
      int d;
      if (pos % 3 == 2) begin
        if (pos == 2) begin
          if (c == ChrColon || c == ChrHyphen) sep = c;
          else dead = 1;
        end else if (c != sep) begin
          dead = 1;
        end
      end else begin
        d = digit_of(c);
        if (d > 15) begin
          dead = 1;
        end else begin
          shift = {shift[MacW-5:0], 4'(d)};
          if (d != 0) nonzero = 1;
        end
      end
      pos = pos + 1'b1;
      if (pos >= BodyLen) phase = PH_TRAIL;
    endfunction

    function void take_char(logic [7:0] c, logic last);
      addr_res_t r;
      if (!dead) begin
        case (phase)
          PH_LEAD: begin
            if (!is_space(c)) begin
              phase = PH_BODY;
              take_body(c);
            end
          end
          PH_BODY: begin
            if (is_space(c)) dead = 1;
            else take_body(c);
          end
          PH_TRAIL: begin
            if (!is_space(c)) dead = 1;
          end
          default: dead = 1;
        endcase
      end
      if (last) begin
        r.ok  = !dead && phase == PH_TRAIL && nonzero && !shift[MulticastBit];
        r.mac = r.ok ? shift : '0;
        pending_addrs.push_back(r);
        clear_parse();
      end
    endfunction

    function void check_addr(logic ok, logic [MacW-1:0] mac);
      addr_res_t want;
      if (pending_addrs.size() == 0) begin
        misses++;
        if (misses <= 10) $display("unexpected result: ok=%0b mac=%012h", ok, mac);
        return;
      end
      want = pending_addrs.pop_front();
      if (ok !== want.ok || mac !== want.mac) begin
        misses++;
        if (misses <= 10)
          $display("mismatch: expected ok=%0b mac=%012h, got ok=%0b mac=%012h",
                   want.ok, want.mac, ok, mac);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall_o;
  logic [7:0]      char_code;
  logic            is_last;
  logic            out_valid_o;
  logic            out_stall = 1'b0;
  logic            addr_ok_o;
  logic [MacW-1:0] mac_value_o;

  bit              calm;
  int              cycles = 0;
  char_req_t       char_stream[$];
  mac_parse_tracker tracker = new();

  mac_address_text_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code),
    .is_last_i  (is_last),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .addr_ok_o  (addr_ok_o),
    .mac_value_o(mac_value_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) tracker.take_char(char_code, is_last);
      if (out_valid_o && !out_stall) tracker.check_addr(addr_ok_o, mac_value_o);
    end
  end

  function automatic logic [7:0] ws_char();
    if ($urandom_range(0, 2) == 0) return ChrSpace;
    return 8'($urandom_range(ChrTab, ChrCr));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return ChrZero + 8'(nib);
    return ($urandom_range(0, 1) ? ChrUpA : ChrLoA) + 8'(nib) - 8'd10;
  endfunction

  task automatic add_text(int kind);
    logic [7:0] s[$];
    logic [7:0] sep;
    logic [7:0] octet;
    bit         zero_addr;
    int         lead;
    int         n;
    sep       = $urandom_range(0, 1) ? ChrColon : ChrHyphen;
    zero_addr = ($urandom_range(0, 9) == 0);
    lead      = $urandom_range(0, 3);
    repeat (lead) s.push_back(ws_char());
    for (int i = 0; i < 6; i++) begin
      octet = zero_addr ? 8'h00 : 8'($urandom);
      if (i == 0 && $urandom_range(0, 2) != 0) octet[0] = 1'b0;
      if (i > 0) s.push_back(sep);
      s.push_back(hex_char(octet[7:4]));
      s.push_back(hex_char(octet[3:0]));
    end
    n = $urandom_range(0, 3);
    repeat (n) s.push_back(ws_char());
    case (kind)
      1: s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
      2: s.delete($urandom_range(lead, lead + 16));
      3: s.insert($urandom_range(0, s.size()), 8'($urandom));
      4: begin
        s.delete();
        n = $urandom_range(1, 20);
        repeat (n) s.push_back(8'($urandom));
      end
      5: begin
        s.delete();
        n = $urandom_range(1, 4);
        repeat (n) s.push_back(ws_char());
      end
      6: s[lead + 3 * $urandom_range(1, 4) + 2] = (sep == ChrColon) ? ChrHyphen : ChrColon;
      default: ;
    endcase
    foreach (s[i]) char_stream.push_back('{code: s[i], last: (i == s.size() - 1)});
  endtask

  initial begin
    string      text;
    int         pick;
    bit         quiet;
    char_req_t  req;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    char_code = '0;
    is_last   = 1'b0;
    calm      = 0;

    // directed: lone bytes, then a padded mixed-case hyphen address
    char_stream.push_back('{code: 8'hFF, last: 1'b1});
    char_stream.push_back('{code: 8'h00, last: 1'b1});
    char_stream.push_back('{code: ChrSpace, last: 1'b1});
    char_stream.push_back('{code: ChrTab, last: 1'b0});
    text = "02-aB-cD-eF-09-f8";
    for (int i = 0; i < text.len(); i++) char_stream.push_back('{code: text[i], last: 1'b0});
    char_stream.push_back('{code: ChrSpace, last: 1'b0});
    char_stream.push_back('{code: ChrCr, last: 1'b1});

    while (char_stream.size() < 1100) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) add_text(0);
      else if (pick < 68) add_text(1);
      else if (pick < 74) add_text(2);
      else if (pick < 80) add_text(3);
      else if (pick < 88) add_text(4);
      else if (pick < 94) add_text(5);
      else add_text(6);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (char_stream[i]) begin
      req   = char_stream[i];
      quiet = (i >= 300 && i < 550);
      calm <= quiet;
      while (!quiet && $urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid  <= 1'b1;
      char_code <= req.code;
      is_last   <= req.last;
      @(posedge clk);
      while (in_stall_o) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (tracker.pending_addrs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.misses == 0 && tracker.pending_addrs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/macp_pkg.sv
sv/macp_char_class.sv
sv/mac_address_text_parser.sv
tb/mac_address_text_parser_tb.sv
